@@ rtl/rvx_pkg.sv @@
// Shared types and constants for the RV32I instruction executor.
// Holds opcode and function codes, the memory request and execute result structs.
// No dependencies.
package rvx_pkg;

  localparam int unsigned MEM_BYTES = 131072;
  localparam logic [31:0] HALT_WORD = 32'h0FF0_0513;

  typedef enum logic [6:0] {
    OPC_LOAD   = 7'd3,
    OPC_OPIMM  = 7'd19,
    OPC_AUIPC  = 7'd23,
    OPC_STORE  = 7'd35,
    OPC_OP     = 7'd51,
    OPC_LUI    = 7'd55,
    OPC_BRANCH = 7'd99,
    OPC_JALR   = 7'd103,
    OPC_JAL    = 7'd111
  } opcode_e;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_SB = 3'd0;
  localparam logic [2:0] F3_SH = 3'd1;
  localparam logic [2:0] F3_SW = 3'd2;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [4:0] REG_A0 = 5'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EXEC,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic        re;
    logic        we;
    logic [31:0] addr;
    logic [3:0]  be;
    logic [31:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic        fail;
    logic        wb;
    logic [31:0] res;
    logic [31:0] npc;
    logic        load;
    logic        store;
    logic [31:0] maddr;
    logic [3:0]  be;
    logic [31:0] wdata;
  } exec_t;

endpackage

@@ rtl/rvx_mem.sv @@
// Byte memory in four synchronous byte lanes with registered read data.
// Serves unaligned and wrapping word accesses; clears itself after reset.
// Depends on rvx_pkg.
module rvx_mem #(
  parameter int unsigned MemBytes = rvx_pkg::MEM_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rvx_pkg::mem_req_t req_i,
  output logic [31:0]       rdata_o,
  output logic              ready_o
);

  localparam int unsigned Rows = MemBytes / 4;
  localparam int unsigned RowW = $clog2(Rows);

  logic [RowW:0]   clr_cnt_q;
  logic            clearing;
  logic [1:0]      off;
  logic [1:0]      off_q;
  logic [RowW-1:0] base;
  logic [7:0]      lane_rd_q [4];

  assign clearing = !clr_cnt_q[RowW];
  assign ready_o  = clr_cnt_q[RowW];
  assign off      = req_i.addr[1:0];
  assign base     = req_i.addr[RowW+1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clearing) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      off_q <= off;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [7:0]      ram_q [Rows];
    logic [1:0]      idx;
    logic [RowW-1:0] row;
    logic            we;
    logic [RowW-1:0] waddr;
    logic [7:0]      wd;

    assign idx = 2'(l) - off;
    assign row = base + ((2'(l) < off) ? RowW'(1) : RowW'(0));

    always_comb begin
      if (clearing) begin
        we    = 1'b1;
        waddr = clr_cnt_q[RowW-1:0];
        wd    = '0;
      end else begin
        we    = req_i.we && req_i.be[idx];
        waddr = row;
        wd    = req_i.wdata[8*idx +: 8];
      end
    end

    always_ff @(posedge clk_i) begin
      if (we) begin
        ram_q[waddr] <= wd;
      end
      if (req_i.re) begin
        lane_rd_q[l] <= ram_q[row];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata_o[8*i +: 8] = lane_rd_q[off_q + 2'(i)];
    end
  end

endmodule

@@ rtl/rvx_regs.sv @@
// Register file of 32 words with two registered read ports and one write port.
// Entries read as zero until written; entry zero is never written.
// Depends on nothing beyond the clock and reset.
module rvx_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        re_i,
  input  logic [4:0]  rs1_i,
  input  logic [4:0]  rs2_i,
  input  logic        we_i,
  input  logic [4:0]  waddr_i,
  input  logic [31:0] wdata_i,
  output logic [31:0] rs1_data_o,
  output logic [31:0] rs2_data_o
);

  logic [31:0] valid_q;
  logic [31:0] ram_q [32];
  logic [31:0] rd1_q;
  logic [31:0] rd2_q;
  logic        v1_q;
  logic        v2_q;
  logic        wr_en;

  assign wr_en = we_i && (waddr_i != 5'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ram_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd1_q <= ram_q[rs1_i];
      rd2_q <= ram_q[rs2_i];
      v1_q  <= valid_q[rs1_i];
      v2_q  <= valid_q[rs2_i];
    end
  end

  assign rs1_data_o = v1_q ? rd1_q : '0;
  assign rs2_data_o = v2_q ? rd2_q : '0;

endmodule

@@ rtl/rvx_exec.sv @@
// Decoder and execute logic for one RV32I instruction word.
// Produces the writeback value, next pc and any memory access.
// Depends on rvx_pkg.
module rvx_exec (
  input  logic [31:0]    instr_i,
  input  logic [31:0]    pc_i,
  input  logic [31:0]    a_i,
  input  logic [31:0]    b_i,
  output rvx_pkg::exec_t ex_o
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic        alt;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic [31:0] op2;
  logic        alt_eff;
  logic [31:0] alu_res;
  logic [4:0]  sh;
  logic        take;

  assign opc   = instr_i[6:0];
  assign f3    = instr_i[14:12];
  assign alt   = instr_i[30];
  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                  instr_i[11:8], 1'b0};
  assign imm_u = {instr_i[31:12], 12'b0};
  assign imm_j = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                  instr_i[30:21], 1'b0};

  assign op2     = (opc == rvx_pkg::OPC_OP) ? b_i : imm_i;
  assign alt_eff = (opc == rvx_pkg::OPC_OP) ? alt : (alt && (f3 == rvx_pkg::F3_SRL));
  assign sh      = op2[4:0];

  always_comb begin
    unique case (f3)
      rvx_pkg::F3_ADD:  alu_res = alt_eff ? a_i - op2 : a_i + op2;
      rvx_pkg::F3_SLL:  alu_res = a_i << sh;
      rvx_pkg::F3_SLT:  alu_res = {31'b0, $signed(a_i) < $signed(op2)};
      rvx_pkg::F3_SLTU: alu_res = {31'b0, a_i < op2};
      rvx_pkg::F3_XOR:  alu_res = a_i ^ op2;
      rvx_pkg::F3_SRL:  alu_res = alt_eff ? 32'($signed(a_i) >>> sh) : a_i >> sh;
      rvx_pkg::F3_OR:   alu_res = a_i | op2;
      default:          alu_res = a_i & op2;
    endcase
  end

  always_comb begin
    take = 1'b0;
    ex_o = '0;
    ex_o.npc = pc_i + 32'd4;
    ex_o.wdata = b_i;
    unique case (opc)
      rvx_pkg::OPC_LUI: begin
        ex_o.res = imm_u;
        ex_o.wb  = 1'b1;
      end
      rvx_pkg::OPC_AUIPC: begin
        ex_o.res = pc_i + imm_u;
        ex_o.wb  = 1'b1;
      end
      rvx_pkg::OPC_JAL: begin
        ex_o.res = pc_i + 32'd4;
        ex_o.wb  = 1'b1;
        ex_o.npc = pc_i + imm_j;
      end
      rvx_pkg::OPC_JALR: begin
        ex_o.res = pc_i + 32'd4;
        ex_o.wb  = 1'b1;
        ex_o.npc = (a_i + imm_i) & ~32'd1;
      end
      rvx_pkg::OPC_BRANCH: begin
        unique case (f3)
          rvx_pkg::F3_BEQ:  take = a_i == b_i;
          rvx_pkg::F3_BNE:  take = a_i != b_i;
          rvx_pkg::F3_BLT:  take = $signed(a_i) < $signed(b_i);
          rvx_pkg::F3_BGE:  take = $signed(a_i) >= $signed(b_i);
          rvx_pkg::F3_BLTU: take = a_i < b_i;
          rvx_pkg::F3_BGEU: take = a_i >= b_i;
          default:          ex_o.fail = 1'b1;
        endcase
        if (take) begin
          ex_o.npc = pc_i + imm_b;
        end
      end
      rvx_pkg::OPC_LOAD: begin
        ex_o.maddr = a_i + imm_i;
        ex_o.wb    = 1'b1;
        ex_o.load  = 1'b1;
        if (!(f3 == rvx_pkg::F3_LB || f3 == rvx_pkg::F3_LH || f3 == rvx_pkg::F3_LW ||
              f3 == rvx_pkg::F3_LBU || f3 == rvx_pkg::F3_LHU)) begin
          ex_o.fail = 1'b1;
        end
      end
      rvx_pkg::OPC_STORE: begin
        ex_o.maddr = a_i + imm_s;
        ex_o.store = 1'b1;
        unique case (f3)
          rvx_pkg::F3_SB: ex_o.be = 4'b0001;
          rvx_pkg::F3_SH: ex_o.be = 4'b0011;
          rvx_pkg::F3_SW: ex_o.be = 4'b1111;
          default:        ex_o.fail = 1'b1;
        endcase
      end
      rvx_pkg::OPC_OPIMM, rvx_pkg::OPC_OP: begin
        ex_o.res = alu_res;
        ex_o.wb  = 1'b1;
      end
      default: ex_o.fail = 1'b1;
    endcase
  end

endmodule

@@ rtl/rv32i_instruction_executor_unit.sv @@
// Top level of the RV32I instruction executor: control sequencer and result register.
// Instantiates rvx_mem, rvx_regs and rvx_exec; depends on rvx_pkg.
//
// An item is taken when start is high and busy is low. With func_i low it writes
// load_byte_i to the byte at load_addr_i; with func_i high it executes the
// instruction at pc. Each item gives one result on next_pc_o, halted_o,
// exit_code_o and decode_fail_o, valid for the single cycle in which done_o is high.
// A byte write, or a step after halt, reports in the cycle after it is taken.
// A step first fetches its instruction by a synchronous read; the halt word then
// reports from DECODE. Otherwise the register file read is registered, and a failed
// decode or most instructions report from EXEC; a load goes on to LOAD for the
// second byte memory read and reports from there.
// busy stays high from an accepted step until its result cycle. The result
// cycle of one item may overlap the acceptance of the next.
// After reset the byte memory is cleared one row of four bytes per cycle, and
// busy is high throughout. Registers, pc and the halt flag reset to zero at once.
// The receiver cannot stall results.
module rv32i_instruction_executor_unit #(
  parameter int unsigned MemBytes = rvx_pkg::MEM_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [16:0] load_addr_i,
  input  logic [7:0]  load_byte_i,
  output logic        done_o,
  output logic [31:0] next_pc_o,
  output logic        halted_o,
  output logic [7:0]  exit_code_o,
  output logic        decode_fail_o
);

  rvx_pkg::state_e   state_q, state_d;
  rvx_pkg::mem_req_t mreq;
  rvx_pkg::exec_t    ex;

  logic [31:0] pc_q, pc_d;
  logic        halt_q, halt_d;
  logic [31:0] instr_q, instr_d;
  logic [7:0]  a0_q;
  logic        done_q;
  logic [31:0] next_pc_q;
  logic        halted_q;
  logic [7:0]  exit_code_q;
  logic        fail_q;

  logic [31:0] mem_rdata;
  logic        mem_ready;
  logic        rf_re;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;
  logic [31:0] rs1_data;
  logic [31:0] rs2_data;
  logic        emit;
  logic        fail;
  logic        accept;

  function automatic logic [31:0] load_fmt(logic [31:0] d, logic [2:0] f3);
    logic [31:0] r;
    unique case (f3)
      rvx_pkg::F3_LB:  r = {{24{d[7]}}, d[7:0]};
      rvx_pkg::F3_LH:  r = {{16{d[15]}}, d[15:0]};
      rvx_pkg::F3_LBU: r = {24'b0, d[7:0]};
      rvx_pkg::F3_LHU: r = {16'b0, d[15:0]};
      default:         r = d;
    endcase
    return r;
  endfunction

  rvx_mem #(
    .MemBytes(MemBytes)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rdata_o(mem_rdata),
    .ready_o(mem_ready)
  );

  rvx_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (rf_re),
    .rs1_i     (mem_rdata[19:15]),
    .rs2_i     (mem_rdata[24:20]),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata),
    .rs1_data_o(rs1_data),
    .rs2_data_o(rs2_data)
  );

  rvx_exec u_exec (
    .instr_i(instr_q),
    .pc_i   (pc_q),
    .a_i    (rs1_data),
    .b_i    (rs2_data),
    .ex_o   (ex)
  );

  assign busy   = (state_q != rvx_pkg::ST_IDLE) || !mem_ready;
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rvx_pkg::ST_IDLE: begin
        if (accept && func_i && !halt_q) begin
          state_d = rvx_pkg::ST_DECODE;
        end
      end
      rvx_pkg::ST_DECODE: begin
        state_d = (mem_rdata == rvx_pkg::HALT_WORD) ? rvx_pkg::ST_IDLE : rvx_pkg::ST_EXEC;
      end
      rvx_pkg::ST_EXEC: begin
        if (!ex.fail && ex.load) begin
          state_d = rvx_pkg::ST_LOAD;
        end else begin
          state_d = rvx_pkg::ST_IDLE;
        end
      end
      default: state_d = rvx_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mreq     = '0;
    rf_re    = 1'b0;
    rf_we    = 1'b0;
    rf_waddr = instr_q[11:7];
    rf_wdata = ex.res;
    emit     = 1'b0;
    fail     = 1'b0;
    pc_d     = pc_q;
    halt_d   = halt_q;
    instr_d  = instr_q;
    unique case (state_q)
      rvx_pkg::ST_IDLE: begin
        if (accept) begin
          if (!func_i) begin
            mreq.we    = 1'b1;
            mreq.addr  = 32'(load_addr_i);
            mreq.be    = 4'b0001;
            mreq.wdata = 32'(load_byte_i);
            emit       = 1'b1;
          end else if (halt_q) begin
            emit = 1'b1;
          end else begin
            mreq.re   = 1'b1;
            mreq.addr = pc_q;
          end
        end
      end
      rvx_pkg::ST_DECODE: begin
        instr_d = mem_rdata;
        if (mem_rdata == rvx_pkg::HALT_WORD) begin
          halt_d = 1'b1;
          emit   = 1'b1;
        end else begin
          rf_re = 1'b1;
        end
      end
      rvx_pkg::ST_EXEC: begin
        if (ex.fail) begin
          emit = 1'b1;
          fail = 1'b1;
        end else if (ex.load) begin
          mreq.re   = 1'b1;
          mreq.addr = ex.maddr;
        end else begin
          mreq.we    = ex.store;
          mreq.addr  = ex.maddr;
          mreq.be    = ex.be;
          mreq.wdata = ex.wdata;
          rf_we      = ex.wb;
          pc_d       = ex.npc;
          emit       = 1'b1;
        end
      end
      default: begin
        rf_we    = 1'b1;
        rf_wdata = load_fmt(mem_rdata, instr_q[14:12]);
        pc_d     = ex.npc;
        emit     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rvx_pkg::ST_IDLE;
      pc_q    <= '0;
      halt_q  <= 1'b0;
      a0_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      done_q  <= emit;
      if (rf_we && (rf_waddr == rvx_pkg::REG_A0)) begin
        a0_q <= rf_wdata[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    instr_q <= instr_d;
    if (emit) begin
      next_pc_q   <= pc_d;
      halted_q    <= halt_d;
      exit_code_q <= halt_d ? a0_q : 8'd0;
      fail_q      <= fail;
    end
  end

  assign done_o        = done_q;
  assign next_pc_o     = next_pc_q;
  assign halted_o      = halted_q;
  assign exit_code_o   = exit_code_q;
  assign decode_fail_o = fail_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(halt_q))
    else $error("Halt flag cleared without reset.");

  a_fail_not_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(decode_fail_o && halted_o))
    else $error("Decode failure reported while halted.");

  a_exit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !halted_o) |-> (exit_code_o == 8'd0))
    else $error("Exit code set while not halted.");

  a_byte_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !func_i) |=> (done_o && !decode_fail_o))
    else $error("Byte write item gave no result in the next cycle.");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the RV32I instruction executor top level.
// Drives byte-write and step items, predicts every result and compares them.
// Depends on rvx_pkg and rv32i_instruction_executor_unit.
module testbench;

  typedef struct {
    logic [31:0] pc;
    logic        halted;
    logic [7:0]  exit_code;
    logic        fail;
  } core_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        func_i = 1'b0;
  logic [16:0] load_addr_i = '0;
  logic [7:0]  load_byte_i = '0;
  logic        done_o;
  logic [31:0] next_pc_o;
  logic        halted_o;
  logic [7:0]  exit_code_o;
  logic        decode_fail_o;

  rv32i_instruction_executor_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [7:0]  model_mem [0:rvx_pkg::MEM_BYTES-1];
  logic [31:0] model_regs [0:31];
  logic [31:0] model_pc;
  logic        model_halt;
  core_result_t pending_results[$];
  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int steps_sent = 0;
  int writes_sent = 0;
  int results_seen = 0;

  function automatic logic [31:0] mem_read(logic [31:0] a, int n);
    logic [31:0] v;
    logic [16:0] wa;
    v = '0;
    for (int i = 0; i < n; i++) begin
      wa = 17'(a + i);
      v[8*i +: 8] = model_mem[wa];
    end
    return v;
  endfunction

  function automatic logic [31:0] alu_op(logic [2:0] f, logic alt, logic [31:0] a,
                                         logic [31:0] b);
    case (f)
      rvx_pkg::F3_ADD:  return alt ? a - b : a + b;
      rvx_pkg::F3_SLL:  return a << b[4:0];
      rvx_pkg::F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      rvx_pkg::F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
      rvx_pkg::F3_XOR:  return a ^ b;
      rvx_pkg::F3_SRL:  return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      rvx_pkg::F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  // Returns 0 when the word does not decode; all state is then left untouched.
  function automatic bit execute_word(logic [31:0] w);
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, res, npc, ea;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        wb, take;
    a = model_regs[w[19:15]];
    b = model_regs[w[24:20]];
    rd = w[11:7];
    f3 = w[14:12];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    res = '0;
    wb = 1'b0;
    take = 1'b0;
    npc = model_pc + 32'd4;
    case (w[6:0])
      rvx_pkg::OPC_LUI: begin res = {w[31:12], 12'd0}; wb = 1'b1; end
      rvx_pkg::OPC_AUIPC: begin res = model_pc + {w[31:12], 12'd0}; wb = 1'b1; end
      rvx_pkg::OPC_JAL: begin
        res = model_pc + 32'd4; wb = 1'b1; npc = model_pc + imm_j;
      end
      rvx_pkg::OPC_JALR: begin
        res = model_pc + 32'd4; wb = 1'b1; npc = (a + imm_i) & ~32'd1;
      end
      rvx_pkg::OPC_BRANCH: begin
        case (f3)
          rvx_pkg::F3_BEQ:  take = a == b;
          rvx_pkg::F3_BNE:  take = a != b;
          rvx_pkg::F3_BLT:  take = $signed(a) < $signed(b);
          rvx_pkg::F3_BGE:  take = !($signed(a) < $signed(b));
          rvx_pkg::F3_BLTU: take = a < b;
          rvx_pkg::F3_BGEU: take = a >= b;
          default: return 1'b0;
        endcase
        if (take) npc = model_pc + imm_b;
      end
      rvx_pkg::OPC_LOAD: begin
        ea = a + imm_i;
        case (f3)
          rvx_pkg::F3_LB:  begin res = mem_read(ea, 1); res = {{24{res[7]}}, res[7:0]}; end
          rvx_pkg::F3_LH:  begin res = mem_read(ea, 2); res = {{16{res[15]}}, res[15:0]}; end
          rvx_pkg::F3_LW:  res = mem_read(ea, 4);
          rvx_pkg::F3_LBU: res = mem_read(ea, 1);
          rvx_pkg::F3_LHU: res = mem_read(ea, 2);
          default: return 1'b0;
        endcase
        wb = 1'b1;
      end
      rvx_pkg::OPC_STORE: begin
        if (f3 > rvx_pkg::F3_SW) return 1'b0;
        ea = a + imm_s;
        for (int i = 0; i < (1 << f3); i++) model_mem[17'(ea + i)] = b[8*i +: 8];
      end
      rvx_pkg::OPC_OPIMM: begin
        res = alu_op(f3, w[30] && f3 == rvx_pkg::F3_SRL, a, imm_i); wb = 1'b1;
      end
      rvx_pkg::OPC_OP: begin res = alu_op(f3, w[30], a, b); wb = 1'b1; end
      default: return 1'b0;
    endcase
    if (wb && rd != 5'd0) model_regs[rd] = res;
    model_pc = npc;
    return 1'b1;
  endfunction

  function automatic void predict_item(logic f, logic [16:0] addr, logic [7:0] data);
    core_result_t r;
    logic [31:0] w;
    r.fail = 1'b0;
    if (!f) begin
      model_mem[addr] = data;
    end else if (!model_halt) begin
      w = mem_read(model_pc, 4);
      if (w == rvx_pkg::HALT_WORD) model_halt = 1'b1;
      else r.fail = !execute_word(w);
    end
    r.pc = model_pc;
    r.halted = model_halt;
    r.exit_code = model_halt ? model_regs[rvx_pkg::REG_A0][7:0] : 8'd0;
    pending_results.push_back(r);
  endfunction

  task automatic send_item(logic f, logic [16:0] addr, logic [7:0] data);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    start <= 1'b1;
    func_i <= f;
    load_addr_i <= addr;
    load_byte_i <= data;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_item(f, addr, data);
    burst_left--;
    if (f) steps_sent++;
    else writes_sent++;
  endtask

  task automatic run_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) send_item(1'b0, 17'(model_pc + i), w[8*i +: 8]);
    send_item(1'b1, 17'($urandom), 8'($urandom));
  endtask

  function automatic logic [31:0] enc_i(rvx_pkg::opcode_e op, logic [2:0] f3,
                                        logic [4:0] rd, logic [4:0] rs1,
                                        logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(rvx_pkg::opcode_e op, logic [2:0] f3,
                                        logic [4:0] rd, logic [4:0] rs1,
                                        logic [4:0] rs2, logic alt);
    return {1'b0, alt, 5'd0, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    rvx_pkg::opcode_e ops [9] = '{rvx_pkg::OPC_LOAD, rvx_pkg::OPC_OPIMM,
                                  rvx_pkg::OPC_AUIPC, rvx_pkg::OPC_STORE,
                                  rvx_pkg::OPC_OP, rvx_pkg::OPC_LUI,
                                  rvx_pkg::OPC_BRANCH, rvx_pkg::OPC_JALR,
                                  rvx_pkg::OPC_JAL};
    w = $urandom;
    if ($urandom_range(0, 9) != 0) begin
      w[6:0] = ops[$urandom_range(0, 8)];
      if ($urandom_range(0, 2) != 0) begin
        w[19:15] = 5'($urandom_range(0, 11));
        w[24:20] = 5'($urandom_range(0, 11));
        w[11:7] = 5'($urandom_range(0, 11));
      end
    end
    if (w == rvx_pkg::HALT_WORD) w[6:0] = rvx_pkg::OPC_OP;
    return w;
  endfunction

  task automatic test_operations();
    run_word(enc_i(rvx_pkg::OPC_OPIMM, rvx_pkg::F3_ADD, 5'd1, 5'd0, 12'h7FF));
    run_word(enc_i(rvx_pkg::OPC_OPIMM, rvx_pkg::F3_ADD, 5'd2, 5'd0, 12'h800));
    run_word({20'h80000, 5'd3, rvx_pkg::OPC_LUI});
    run_word({20'hFFFFF, 5'd4, rvx_pkg::OPC_AUIPC});
    run_word(enc_r(rvx_pkg::OPC_OP, rvx_pkg::F3_ADD, 5'd5, 5'd1, 5'd2, 1'b1));
    run_word(enc_r(rvx_pkg::OPC_OP, rvx_pkg::F3_SRL, 5'd6, 5'd3, 5'd1, 1'b1));
    run_word(enc_r(rvx_pkg::OPC_OP, rvx_pkg::F3_SRL, 5'd6, 5'd3, 5'd1, 1'b0));
    for (int f = 0; f < 8; f++) begin
      run_word(enc_r(rvx_pkg::OPC_OP, 3'(f), 5'd7, 5'd2, 5'd3, 1'b0));
      run_word(enc_i(rvx_pkg::OPC_OPIMM, 3'(f), 5'd8, 5'd3,
                     12'(f == 5 ? 12'h41F : 12'h813)));
    end
    run_word(enc_i(rvx_pkg::OPC_OPIMM, rvx_pkg::F3_SLTU, 5'd9, 5'd2, 12'h001));
    run_word(enc_i(rvx_pkg::OPC_OPIMM, rvx_pkg::F3_ADD, 5'd0, 5'd1, 12'h123));
    run_word(enc_i(rvx_pkg::OPC_OPIMM, rvx_pkg::F3_ADD, 5'd11, 5'd0, 12'h7FD));
    run_word({12'd0, 5'd11, rvx_pkg::F3_SW, 5'd0, rvx_pkg::OPC_STORE} | {7'h3F, 25'd0});
    run_word({7'd0, 5'd2, 5'd0, rvx_pkg::F3_SH, 5'd16, rvx_pkg::OPC_STORE});
    run_word({7'd0, 5'd3, 5'd0, rvx_pkg::F3_SB, 5'd20, rvx_pkg::OPC_STORE});
    for (int f = 0; f < 8; f++) begin
      run_word(enc_i(rvx_pkg::OPC_LOAD, 3'(f), 5'd12, 5'd2, 12'h800));
    end
    for (int f = 0; f < 8; f++) begin
      run_word({7'd0, 5'd1, 5'd2, 3'(f), 5'd8, rvx_pkg::OPC_BRANCH});
    end
    run_word({7'd0, 5'd0, 5'd0, 3'd3, 5'd0, rvx_pkg::OPC_STORE});
    run_word(32'h0000_007F);
    run_word({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd1, rvx_pkg::OPC_JAL});
    run_word(enc_i(rvx_pkg::OPC_JALR, 3'd5, 5'd13, 5'd1, 12'h801));
  endtask

  task automatic test_random_program();
    for (int n = 0; n < 100; n++) begin
      if ($urandom_range(0, 5) == 0) send_item(1'b0, 17'($urandom), 8'($urandom));
      if ($urandom_range(0, 7) == 0) send_item(1'b1, 17'($urandom), 8'($urandom));
      else run_word(random_word());
    end
  endtask

  task automatic test_halt();
    run_word(enc_i(rvx_pkg::OPC_OPIMM, rvx_pkg::F3_ADD, rvx_pkg::REG_A0, 5'd0,
                   12'(8'($urandom))));
    run_word(rvx_pkg::HALT_WORD);
    for (int i = 0; i < 6; i++) begin
      send_item(1'($urandom_range(0, 1)), 17'($urandom), 8'($urandom));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      core_result_t e;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result without a pending item, pc %h", next_pc_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (next_pc_o !== e.pc) begin
          $error("next_pc expected %h actual %h", e.pc, next_pc_o); errors++;
        end
        if (halted_o !== e.halted) begin
          $error("halted expected %b actual %b", e.halted, halted_o); errors++;
        end
        if (exit_code_o !== e.exit_code) begin
          $error("exit_code expected %h actual %h", e.exit_code, exit_code_o); errors++;
        end
        if (decode_fail_o !== e.fail) begin
          $error("decode_fail expected %b actual %b", e.fail, decode_fail_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 100000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < rvx_pkg::MEM_BYTES; i++) model_mem[i] = 8'd0;
    for (int i = 0; i < 32; i++) model_regs[i] = 32'd0;
    model_pc = '0;
    model_halt = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_operations();
    test_random_program();
    test_halt();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) errors++;
    $display("Covered %0d steps and %0d byte writes, %0d results checked.",
             steps_sent, writes_sent, results_seen);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/rvx_pkg.sv
rtl/rvx_mem.sv
rtl/rvx_regs.sv
rtl/rvx_exec.sv
rtl/rv32i_instruction_executor_unit.sv
test/testbench.sv
